[sv/disjoint_interval_set_unit_defines.svh]
// assertion helpers for the interval set unit
`ifndef DISJOINT_INTERVAL_SET_UNIT_DEFINES_SVH
`define DISJOINT_INTERVAL_SET_UNIT_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define DISU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define DISU_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[sv/disu_pkg.sv]
package disu_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_POINT  = 2'd2,
        CMD_RANGE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHL,
        CELL_SHR
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DELETE
    } state_t;

    typedef struct packed {
        cell_op_t op;
        logic     set_start;
        logic     set_end;
        logic     kill_set;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] range_start;
        logic signed [31:0] range_end;
    } item_t;

    typedef struct packed {
        logic signed [31:0] found_start;
        logic signed [31:0] found_end;
        logic               covered;
        logic [1:0]         status;
    } result_t;

endpackage

[sv/disu_cell.sv]
module disu_cell #(
    parameter int CW = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  disu_pkg::cell_ctrl_t ctrl,
    input  logic signed [CW-1:0] lo,
    input  logic signed [CW-1:0] hi,
    input  logic signed [CW-1:0] ld_start,
    input  logic signed [CW-1:0] ld_end,
    input  logic signed [CW-1:0] left_start,
    input  logic signed [CW-1:0] left_end,
    input  logic                left_valid,
    input  logic signed [CW-1:0] right_start,
    input  logic signed [CW-1:0] right_end,
    input  logic                right_valid,
    input  logic                right_kill,
    output logic signed [CW-1:0] cell_start,
    output logic signed [CW-1:0] cell_end,
    output logic                cell_valid,
    output logic                cell_kill
);
    import disu_pkg::*;

    logic signed [CW-1:0] start_reg, start_next;
    logic signed [CW-1:0] end_reg, end_next;
    logic                 valid_reg, valid_next;
    logic                 kill_reg, kill_next;

    // pick source entry, then clip bounds
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        valid_next = valid_reg;
        kill_next  = kill_reg | ctrl.kill_set;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_LOAD:
            begin
                start_next = ld_start;
                end_next   = ld_end;
                valid_next = 1'b1;
            end
            CELL_SHL:
            begin
                start_next = right_start;
                end_next   = right_end;
                valid_next = right_valid;
                kill_next  = right_kill;
            end
            CELL_SHR:
            begin
                start_next = left_start;
                end_next   = left_end;
                valid_next = left_valid;
                kill_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (ctrl.set_start)
        begin
            start_next = hi;
        end
        if (ctrl.set_end)
        begin
            end_next = lo;
        end
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kill_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            kill_reg  <= kill_next;
        end
    end

    // interval bounds
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign cell_start = start_reg;
    assign cell_end   = end_reg;
    assign cell_valid = valid_reg;
    assign cell_kill  = kill_reg;

endmodule

[sv/disjoint_interval_set_unit.sv]
// Interval set unit: a sorted table of up to CAPACITY disjoint, non-touching
// half-open intervals [lo,hi), held in a row of cells, one interval per cell.
// Command channel: drive item and raise start; the item is taken at a clock
// edge where start is high and busy is low. Commands are insert (merge with
// overlapping or touching intervals), erase (clip or split), point query and
// range containment query.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver must take it then. busy drops in the same cycle, so a new item
// may be taken while the result is shown.
// Operation: the item is registered, then every cell compares against the
// item and the table is shifted or clipped in place, then the result is shown.
// An insert that swallows more than one stored interval, or an erase that
// removes whole intervals, then passes a delete phase in which the row
// shifts left by one cell per cycle until every removed entry is gone.
// Reset empties the table at once (no clearing pass) and returns to idle.
// Coordinates are the low min(COORD_BITS,32) bits, two's complement.
module disjoint_interval_set_unit #(
    parameter int CAPACITY   = 16,
    parameter int COORD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  disu_pkg::item_t   item,
    output logic              done,
    output disu_pkg::result_t result
);
    import disu_pkg::*;
    `include "disjoint_interval_set_unit_defines.svh"

    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;

    state_t state_reg, state_next;

    logic [1:0]           cmd_reg;
    logic signed [CW-1:0] lo_reg, hi_reg;
    logic [CAPACITY-1:0]  shl_reg, shl_next;
    logic                 done_reg, done_next;
    result_t              res_reg, res_next;

    logic signed [CW-1:0] cs [CAPACITY];
    logic signed [CW-1:0] ce [CAPACITY];
    logic [CAPACITY-1:0]  cv, ck;
    cell_ctrl_t           ctrl [CAPACITY];

    logic [CAPACITY-1:0] ovi, ove, ltl, hie, cov, gtl, gthi, gehi;
    logic [CAPACITY-1:0] f_ins, l_ins, p_ins, sp, spp, covm, kill_mask;
    logic signed [CW-1:0] sel_s, sel_e, cov_s, cov_e, mlo, mhi, ld_s, ld_e;
    logic any_ov, any_sp, any_cov, lo_gt_hi, lo_lt_hi, full, last_kill;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [CW-1:0] l_s, l_e, r_s, r_e;
        logic                 l_v, r_v, r_k;
        if (i == 0)
        begin : g_first
            assign l_s = '0;
            assign l_e = '0;
            assign l_v = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_s = cs[i-1];
            assign l_e = ce[i-1];
            assign l_v = cv[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign r_s = '0;
            assign r_e = '0;
            assign r_v = 1'b0;
            assign r_k = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_s = cs[i+1];
            assign r_e = ce[i+1];
            assign r_v = cv[i+1];
            assign r_k = ck[i+1];
        end
        disu_cell #(.CW(CW)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl[i]),
            .lo          (lo_reg),
            .hi          (hi_reg),
            .ld_start    (ld_s),
            .ld_end      (ld_e),
            .left_start  (l_s),
            .left_end    (l_e),
            .left_valid  (l_v),
            .right_start (r_s),
            .right_end   (r_e),
            .right_valid (r_v),
            .right_kill  (r_k),
            .cell_start  (cs[i]),
            .cell_end    (ce[i]),
            .cell_valid  (cv[i]),
            .cell_kill   (ck[i])
        );
    end

    // per-cell compares against the held item
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ovi[i]  = cv[i] && (ce[i] >= lo_reg) && (cs[i] <= hi_reg);
            ove[i]  = cv[i] && (cs[i] < hi_reg) && (ce[i] > lo_reg);
            ltl[i]  = cs[i] < lo_reg;
            hie[i]  = hi_reg < ce[i];
            cov[i]  = cv[i] && (cs[i] <= lo_reg) && (lo_reg < ce[i]);
            gtl[i]  = !cv[i] || (cs[i] > lo_reg);
            gthi[i] = !cv[i] || (cs[i] > hi_reg);
            gehi[i] = !cv[i] || (cs[i] >= hi_reg);
        end
        f_ins = ovi & ~{ovi[CAPACITY-2:0], 1'b0};
        l_ins = ovi & ~{1'b0, ovi[CAPACITY-1:1]};
        p_ins = gtl & ~{gtl[CAPACITY-2:0], 1'b0};
        sp    = ove & ltl & hie;
        spp   = {sp[CAPACITY-2:0], 1'b0};
        covm  = ove & ~ltl & ~hie;
    end

    // one-hot selects of the merge ends and the covering entry
    always_comb
    begin
        sel_s = '0;
        sel_e = '0;
        cov_s = '0;
        cov_e = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_s = sel_s | (f_ins[i] ? cs[i] : '0);
            sel_e = sel_e | (l_ins[i] ? ce[i] : '0);
            cov_s = cov_s | (cov[i] ? cs[i] : '0);
            cov_e = cov_e | (cov[i] ? ce[i] : '0);
        end
        any_ov   = |ovi;
        any_sp   = |sp;
        any_cov  = |cov;
        lo_gt_hi = lo_reg > hi_reg;
        lo_lt_hi = lo_reg < hi_reg;
        full     = cv[CAPACITY-1];
        mlo      = (any_ov && (sel_s < lo_reg)) ? sel_s : lo_reg;
        mhi      = (any_ov && (sel_e > hi_reg)) ? sel_e : hi_reg;
        ld_s     = mlo;
        ld_e     = mhi;
        last_kill = (ck & (ck - 1'b1)) == '0;
    end

    // cell control and shift mask
    always_comb
    begin
        shl_next = shl_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i] = '{op: CELL_HOLD, set_start: 1'b0, set_end: 1'b0, kill_set: 1'b0};
        end
        unique case (state_reg)
            S_EVAL:
            begin
                if ((cmd_reg == CMD_INSERT) && lo_lt_hi)
                begin
                    if (any_ov)
                    begin
                        shl_next = (ovi & ~f_ins) | gthi;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (f_ins[i])
                            begin
                                ctrl[i].op = CELL_LOAD;
                            end
                            else if (ovi[i])
                            begin
                                ctrl[i].kill_set = 1'b1;
                            end
                        end
                    end
                    else if (!full)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (p_ins[i])
                            begin
                                ctrl[i].op = CELL_LOAD;
                            end
                            else if (gtl[i])
                            begin
                                ctrl[i].op = CELL_SHR;
                            end
                        end
                    end
                end
                else if ((cmd_reg == CMD_ERASE) && lo_lt_hi)
                begin
                    if (any_sp)
                    begin
                        if (!full)
                        begin
                            for (int i = 0; i < CAPACITY; i++)
                            begin
                                if (sp[i])
                                begin
                                    ctrl[i].set_end = 1'b1;
                                end
                                else if (spp[i])
                                begin
                                    ctrl[i].op        = CELL_SHR;
                                    ctrl[i].set_start = 1'b1;
                                end
                                else if (gehi[i])
                                begin
                                    ctrl[i].op = CELL_SHR;
                                end
                            end
                        end
                    end
                    else
                    begin
                        shl_next = covm | (ove & hie) | gehi;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            ctrl[i].set_end   = ove[i] && ltl[i];
                            ctrl[i].set_start = ove[i] && hie[i];
                            ctrl[i].kill_set  = covm[i];
                        end
                    end
                end
            end
            S_DELETE:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (shl_reg[i])
                    begin
                        ctrl[i].op = CELL_SHL;
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < CAPACITY; i++)
        begin
            kill_mask[i] = ctrl[i].kill_set;
        end
    end

    // result of the held item
    always_comb
    begin
        res_next.found_start = 32'(lo_reg);
        res_next.found_end   = 32'(hi_reg);
        res_next.covered     = 1'b0;
        res_next.status      = ST_OK;
        priority if (cmd_reg == CMD_POINT)
        begin
            res_next.found_start = any_cov ? 32'(cov_s) : 32'(lo_reg);
            res_next.found_end   = any_cov ? 32'(cov_e) : 32'(lo_reg);
            res_next.covered     = any_cov;
        end
        else if (lo_gt_hi)
        begin
            res_next.status = ST_ORDER;
        end
        else if (cmd_reg == CMD_RANGE)
        begin
            res_next.found_start = any_cov ? 32'(cov_s) : 32'(lo_reg);
            res_next.found_end   = any_cov ? 32'(cov_e) : 32'(lo_reg);
            res_next.covered     = any_cov ? (hi_reg <= cov_e) : !lo_lt_hi;
        end
        else if (cmd_reg == CMD_INSERT)
        begin
            if (!lo_lt_hi)
            begin
                res_next.found_end = 32'(lo_reg);
            end
            else if (!any_ov && full)
            begin
                res_next.status = ST_FULL;
            end
            else
            begin
                res_next.found_start = 32'(mlo);
                res_next.found_end   = 32'(mhi);
            end
        end
        else
        begin
            if (lo_lt_hi && any_sp && full)
            begin
                res_next.status = ST_FULL;
            end
            else
            begin
                res_next.found_start = '0;
                res_next.found_end   = '0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = (|kill_mask) ? S_DELETE : S_IDLE;
            end
            S_DELETE:
            begin
                if (last_kill)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        busy      = state_reg != S_IDLE;
        done_next = ((state_reg == S_EVAL) && !(|kill_mask))
                    || ((state_reg == S_DELETE) && last_kill);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // item, shift mask and result holding
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= item.command;
            lo_reg  <= item.range_start[CW-1:0];
            hi_reg  <= item.range_end[CW-1:0];
        end
        shl_reg <= shl_next;
        if (state_reg == S_EVAL)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    // checks
    `DISU_ASSERT(a_valid_prefix, ((cv & (cv + 1'b1)) == '0), "valid entries not a prefix")
    `DISU_ASSERT(a_no_kill_idle, ((state_reg != S_IDLE) || (ck == '0)), "kill mark left in idle")
    `DISU_ASSERT(a_done_idle, (!done_reg || (state_reg == S_IDLE)), "result shown while busy")
    `DISU_ASSERT_NEXT(a_accept_eval, (start && !busy), (state_reg == S_EVAL), "item not evaluated")

endmodule
